[sv/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// Page free-list allocator package
// Widths, request and status codes and the sequencer state type shared by
// the allocator modules.
// ----------------------------------------------------------------------------
package pfla_pkg;

    // Page addresses and region bounds
    localparam int ADDR_BITS     = 34;
    localparam int STOP_BITS     = 35;
    localparam int PAGE_SHIFT    = 12;
    localparam int PAGE_BYTES    = 1 << PAGE_SHIFT;
    // Page numbers cover the whole stop range
    localparam int PN_W          = STOP_BITS - PAGE_SHIFT;
    localparam int PAGES_DEFAULT = 32768;

    // Stream widths
    localparam int TDATA_W       = 40;
    localparam int TUSER_W       = 2;
    localparam int CFG_INDEX_W   = 1;

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_INIT  = 2'd2,
        REQ_NONE  = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_BAD_FREE = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_REGION_START = 1'b0,
        CFG_REGION_STOP  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_EXEC = 3'b010,
        S_INIT = 3'b100
    } state_t;

endpackage

[sv/pfla_next_ram.sv]
// ----------------------------------------------------------------------------
// Next-link memory
// Simple dual-port synchronous RAM holding one link per page: one write and
// one registered read each cycle.
// ----------------------------------------------------------------------------
module pfla_next_ram #(
    parameter int DEPTH = pfla_pkg::PAGES_DEFAULT,
    parameter int WIDTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[sv/pfla_engine.sv]
// ----------------------------------------------------------------------------
// Allocator sequencer
// Executes one request at a time against the link memory: pops the head on
// an alloc, checks and pushes a page on a free, and walks the region on init.
// ----------------------------------------------------------------------------
module pfla_engine #(
    parameter int PAGES = pfla_pkg::PAGES_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    // request side
    input  logic                                 req_valid,
    output logic                                 req_ready,
    input  pfla_pkg::req_type_t                  req_type,
    input  logic [pfla_pkg::ADDR_BITS-1:0]       page_address,
    // result side
    output logic                                 res_valid,
    input  logic                                 res_ready,
    output logic [pfla_pkg::ADDR_BITS-1:0]       granted_address,
    output pfla_pkg::status_t                    status,
    // region
    input  logic [pfla_pkg::ADDR_BITS-1:0]       region_start,
    input  logic [pfla_pkg::STOP_BITS-1:0]       region_stop,
    input  logic [pfla_pkg::PN_W-1:0]            base_pages,
    // link memory
    output logic                                 mem_we,
    output logic [$clog2(PAGES)-1:0]             mem_waddr,
    output logic [$clog2(PAGES):0]               mem_wdata,
    output logic [$clog2(PAGES)-1:0]             mem_raddr,
    input  logic [$clog2(PAGES):0]               mem_rdata
);

    localparam int IDX_W = $clog2(PAGES);
    localparam int CNT_W = $clog2(PAGES + 1);
    localparam int PN_W  = pfla_pkg::PN_W;
    localparam int SHIFT = pfla_pkg::PAGE_SHIFT;
    localparam int AB    = pfla_pkg::ADDR_BITS;
    localparam int SB    = pfla_pkg::STOP_BITS;

    pfla_pkg::state_t    state_reg, state_next;
    pfla_pkg::req_type_t req_reg, req_next;
    logic [AB-1:0]       addr_reg, addr_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic                head_valid_reg, head_valid_next;
    logic [CNT_W-1:0]    cursor_reg, cursor_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                res_valid_reg, res_valid_next;
    logic [AB-1:0]       res_addr_reg, res_addr_next;
    pfla_pkg::status_t   res_status_reg, res_status_next;

    logic                out_free;
    logic [PN_W-1:0]     addr_pages;
    logic [PN_W-1:0]     free_diff;
    logic                free_ok;
    logic [PN_W-1:0]     stop_pages;
    logic [PN_W-1:0]     init_diff;
    logic [CNT_W-1:0]    init_count;
    logic [IDX_W-1:0]    rd_idx;
    logic                rd_end;
    logic [PN_W:0]       granted_pages;
    logic [PN_W+SHIFT:0] granted_full;

    assign out_free = !res_valid_reg || res_ready;

    // A page that is aligned and not below region_start cannot sit below the
    // rounded-up base, so the difference never wraps when it is used.
    assign addr_pages = {1'b0, addr_reg[AB-1:SHIFT]};
    assign free_diff  = addr_pages - base_pages;
    assign free_ok    = (addr_reg[SHIFT-1:0] == '0)
                        && (addr_reg >= region_start)
                        && ({1'b0, addr_reg} < region_stop)
                        && (free_diff < PN_W'(PAGES));

    assign stop_pages = region_stop[SB-1:SHIFT];
    assign init_diff  = stop_pages - base_pages;
    always_comb begin
        if (stop_pages <= base_pages) begin
            init_count = '0;
        end else if (init_diff > PN_W'(PAGES)) begin
            init_count = CNT_W'(PAGES);
        end else begin
            init_count = init_diff[CNT_W-1:0];
        end
    end

    assign rd_idx        = mem_rdata[IDX_W-1:0];
    assign rd_end        = mem_rdata[IDX_W];
    assign granted_pages = {1'b0, base_pages} + (PN_W + 1)'(head_reg);
    assign granted_full  = {granted_pages, {SHIFT{1'b0}}};

    // The head link is read every cycle; it is stable from acceptance onwards.
    assign mem_raddr = head_reg;
    assign mem_wdata = {!head_valid_reg, head_reg};

    always_comb begin
        state_next      = state_reg;
        req_next        = req_reg;
        addr_next       = addr_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        cursor_next     = cursor_reg;
        count_next      = count_reg;
        res_valid_next  = res_valid_reg && !res_ready;
        res_addr_next   = res_addr_reg;
        res_status_next = res_status_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;

        case (state_reg)
            pfla_pkg::S_IDLE: begin
                if (req_valid) begin
                    req_next   = req_type;
                    addr_next  = page_address;
                    state_next = pfla_pkg::S_EXEC;
                end
            end
            pfla_pkg::S_EXEC: begin
                if (req_reg == pfla_pkg::REQ_INIT) begin
                    count_next  = init_count;
                    cursor_next = '0;
                    state_next  = pfla_pkg::S_INIT;
                end else if (out_free) begin
                    res_valid_next  = 1'b1;
                    res_addr_next   = '0;
                    res_status_next = pfla_pkg::STAT_OK;
                    state_next      = pfla_pkg::S_IDLE;
                    case (req_reg)
                        pfla_pkg::REQ_ALLOC: begin
                            if (head_valid_reg) begin
                                res_addr_next   = granted_full[AB-1:0];
                                head_next       = rd_idx;
                                head_valid_next = !rd_end;
                            end else begin
                                res_status_next = pfla_pkg::STAT_EMPTY;
                            end
                        end
                        pfla_pkg::REQ_FREE: begin
                            if (free_ok) begin
                                mem_we          = 1'b1;
                                mem_waddr       = free_diff[IDX_W-1:0];
                                head_next       = free_diff[IDX_W-1:0];
                                head_valid_next = 1'b1;
                            end else begin
                                res_status_next = pfla_pkg::STAT_BAD_FREE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            pfla_pkg::S_INIT: begin
                if (cursor_reg == count_reg) begin
                    if (out_free) begin
                        res_valid_next  = 1'b1;
                        res_addr_next   = '0;
                        res_status_next = pfla_pkg::STAT_OK;
                        state_next      = pfla_pkg::S_IDLE;
                    end
                end else begin
                    mem_we          = 1'b1;
                    mem_waddr       = cursor_reg[IDX_W-1:0];
                    head_next       = cursor_reg[IDX_W-1:0];
                    head_valid_next = 1'b1;
                    cursor_next     = cursor_reg + 1'b1;
                end
            end
            default: begin
                state_next = pfla_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= pfla_pkg::S_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            cursor_reg     <= '0;
            count_reg      <= '0;
            res_valid_reg  <= 1'b0;
        end else begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            cursor_reg     <= cursor_next;
            count_reg      <= count_next;
            res_valid_reg  <= res_valid_next;
        end
        req_reg        <= req_next;
        addr_reg       <= addr_next;
        res_addr_reg   <= res_addr_next;
        res_status_reg <= res_status_next;
    end

    assign req_ready       = (state_reg == pfla_pkg::S_IDLE);
    assign res_valid       = res_valid_reg;
    assign granted_address = res_addr_reg;
    assign status          = res_status_reg;

    // The list can only become empty by popping its last page.
    a_empty_by_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(head_valid_reg) |-> $past(state_reg == pfla_pkg::S_EXEC
                                        && req_reg == pfla_pkg::REQ_ALLOC))
        else $error("free list emptied outside an alloc");

    // Links are written only while a free or an init is being carried out.
    a_write_in_exec: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == pfla_pkg::S_EXEC || state_reg == pfla_pkg::S_INIT))
        else $error("link written outside request execution");

    // The init walk never passes its page count.
    a_cursor_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == pfla_pkg::S_INIT) |-> (cursor_reg <= count_reg))
        else $error("init cursor beyond page count");

    // Only a successful alloc returns a non-zero address.
    a_addr_only_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (res_valid_reg && res_status_reg != pfla_pkg::STAT_OK) |-> (res_addr_reg == '0))
        else $error("address returned with an error status");

    // Results appear only when the sequencer leaves a request.
    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(res_valid_reg) |-> $past(state_reg == pfla_pkg::S_EXEC
                                       || state_reg == pfla_pkg::S_INIT))
        else $error("result raised outside request execution");

endmodule

[sv/page_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// Page free-list allocator
// Hands out and takes back fixed-size physical pages through a last-in
// first-out free list threaded through a per-page link memory.
// ----------------------------------------------------------------------------
// Usage: set region_start and region_stop on the write port, then send an
// init request to build the list from the region. Requests arrive on the s_
// channel (s_tuser carries the request type, s_tdata the page address for a
// free); every request gives exactly one result on the m_ channel with the
// granted address in m_tdata and the status in m_tuser.
// Alloc, free and the unused code present their result from the execution
// state that follows acceptance, once the output register is free; during
// execution the registered read of the head link is available for the pop.
// An init writes one link per cycle through the single memory write port,
// one for each pushed page, and then presents its result. Requests are
// accepted one at a time, only while the sequencer is idle.
// Reset empties the list and clears the region registers; the link memory
// needs no clearing, as a link is always written before it is read.
// When the receiver stalls, the finished result is held in the output register
// and one further request may be accepted; it waits in execution, or an init at
// the end of its walk, until the output register is free.
// ----------------------------------------------------------------------------
module page_free_list_allocator #(
    parameter int PAGES = pfla_pkg::PAGES_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // request channel
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pfla_pkg::TDATA_W-1:0]       s_tdata,   // [33:0] page_address
    input  logic [pfla_pkg::TUSER_W-1:0]       s_tuser,   // [1:0] req_type
    // result channel
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pfla_pkg::TDATA_W-1:0]       m_tdata,   // [33:0] granted_address
    output logic [pfla_pkg::TUSER_W-1:0]       m_tuser,   // [1:0] status
    // configuration
    input  logic                               cfg_we,
    input  logic [pfla_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pfla_pkg::STOP_BITS-1:0]     cfg_wdata
);

    localparam int IDX_W = $clog2(PAGES);
    localparam int AB    = pfla_pkg::ADDR_BITS;
    localparam int SB    = pfla_pkg::STOP_BITS;

    logic [AB-1:0]            region_start_reg;
    logic [SB-1:0]            region_stop_reg;
    logic [pfla_pkg::PN_W-1:0] base_pages_reg;
    logic [SB-1:0]            start_round;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic [IDX_W:0]           mem_wdata;
    logic [IDX_W-1:0]         mem_raddr;
    logic [IDX_W:0]           mem_rdata;

    logic [AB-1:0]            granted_address;
    pfla_pkg::status_t        status;

    // The page base is region_start rounded up to a whole page, kept as a
    // page number so that requests need no rounding of their own.
    assign start_round = {1'b0, cfg_wdata[AB-1:0]} + SB'(pfla_pkg::PAGE_BYTES - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            region_start_reg <= '0;
            region_stop_reg  <= '0;
            base_pages_reg   <= '0;
        end else if (cfg_we) begin
            case (pfla_pkg::cfg_index_t'(cfg_index))
                pfla_pkg::CFG_REGION_START: begin
                    region_start_reg <= cfg_wdata[AB-1:0];
                    base_pages_reg   <= start_round[SB-1:pfla_pkg::PAGE_SHIFT];
                end
                pfla_pkg::CFG_REGION_STOP: begin
                    region_stop_reg <= cfg_wdata;
                end
                default: begin
                end
            endcase
        end
    end

    pfla_next_ram #(
        .DEPTH (PAGES),
        .WIDTH (IDX_W + 1)
    ) u_next_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    pfla_engine #(
        .PAGES (PAGES)
    ) u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .req_valid       (s_tvalid),
        .req_ready       (s_tready),
        .req_type        (pfla_pkg::req_type_t'(s_tuser)),
        .page_address    (s_tdata[AB-1:0]),
        .res_valid       (m_tvalid),
        .res_ready       (m_tready),
        .granted_address (granted_address),
        .status          (status),
        .region_start    (region_start_reg),
        .region_stop     (region_stop_reg),
        .base_pages      (base_pages_reg),
        .mem_we          (mem_we),
        .mem_waddr       (mem_waddr),
        .mem_wdata       (mem_wdata),
        .mem_raddr       (mem_raddr),
        .mem_rdata       (mem_rdata)
    );

    assign m_tdata = {{(pfla_pkg::TDATA_W - AB){1'b0}}, granted_address};
    assign m_tuser = status;

endmodule
